/* rtl/ptbe_pkg.sv */
package ptbe_pkg;

  localparam int unsigned SAMPLE_W       = 8;
  localparam int unsigned MAX_FRAMES_DEF = 32;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef enum logic [1:0] {
    MODE_MIN    = 2'd0,
    MODE_MINMAX = 2'd1,
    MODE_AVG    = 2'd2,
    MODE_MEDIAN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2,
    ST_LOAD = 2'd3
  } state_t;

  // What one sorter cell shows its right-hand neighbor.
  typedef struct packed {
    logic [SAMPLE_W-1:0] val;
    logic                valid;
    logic                gt;     // valid and val greater than the incoming sample
  } link_t;

endpackage

/* rtl/ptbe_cell.sv */
module ptbe_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ins,
  input  logic                          clr,
  input  logic [ptbe_pkg::SAMPLE_W-1:0] sample,
  input  ptbe_pkg::link_t               left,
  output ptbe_pkg::link_t               right
);

  logic [ptbe_pkg::SAMPLE_W-1:0] val_r, val_nxt;
  logic                          valid_r, valid_nxt;
  logic                          gt;

  assign gt = valid_r && (val_r > sample);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (clr) begin
      valid_nxt = 1'b0;
    end else if (ins) begin
      if (left.gt) begin
        // shift the larger neighbor value in
        val_nxt   = left.val;
        valid_nxt = 1'b1;
      end else if (left.valid && (gt || !valid_r)) begin
        // insertion point
        val_nxt   = sample;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    val_r <= val_nxt;
  end

  assign right.val   = val_r;
  assign right.valid = valid_r;
  assign right.gt    = gt;

endmodule

/* rtl/ptbe_div.sv */
module ptbe_div #(
  parameter int unsigned SUM_W = 14,
  parameter int unsigned CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient,
  output logic [CNT_W-1:0] remainder
);

  localparam int unsigned IT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W:0]   trial;
  logic             ge;
  logic [CNT_W:0]   diff;

  // One quotient bit per cycle, restoring.
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    it_nxt   = it_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      it_nxt   = IT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      it_nxt  = it_r - IT_W'(1);
      if (it_r == IT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/pixel_temporal_background_estimator_core.sv */
// Channel  | Ports                                         | Direction
// input    | in_valid, in_stall, in_pixel_sample,          | samples in
//          | in_window_end                                 |
// result   | out_valid, out_stall, out_background_value,   | one beat per window
//          | out_window_error                              |
// config   | cfg_wr_en, cfg_wr_data                        | mode register
//
// A non-closing sample beat is registered into the sorter chain; the next beat
// may follow at once. A closing beat then passes through the evaluation and
// load states, with the divide state between them in average mode.
// Reset clears control state; the chain empties through its valid bits.
// in_stall is high from the closing beat until its result is loaded; a stalled
// result beat holds the register while the next window's samples are taken.
module pixel_temporal_background_estimator_core #(
  parameter int unsigned MAX_FRAMES = ptbe_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptbe_pkg::SAMPLE_W-1:0] in_pixel_sample,
  input  logic                          in_window_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ptbe_pkg::SAMPLE_W-1:0] out_background_value,
  output logic                          out_window_error
);

  localparam int unsigned SW    = ptbe_pkg::SAMPLE_W;
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned SUM_W = SW + CNT_W;

  ptbe_pkg::mode_t  mode_r, mode_nxt;
  ptbe_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SW-1:0]    rmin_r, rmin_nxt;
  logic [SW-1:0]    pfirst_r, pfirst_nxt;
  logic             popen_r, popen_nxt;
  logic [SW-1:0]    pmin_r, pmin_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  logic [SW-1:0]    est_r, est_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [SW-1:0]    out_val_r, out_val_nxt;
  logic             out_err_r, out_err_nxt;

  logic             accept;
  logic             room;
  logic             ins;
  logic             clr;
  logic             load;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_q;
  logic [CNT_W-1:0] div_r;
  logic [SW-1:0]    pair_hi;
  logic [SW-1:0]    est_now;
  logic [SW-1:0]    avg_round;
  logic [CNT_W-1:0] med_full;
  logic [IDX_W-1:0] med_idx;
  logic [CNT_W:0]   twice_rem;
  logic             round_up;
  logic [SUM_W:0]   q_round;

  ptbe_pkg::link_t  links [MAX_FRAMES+1];
  logic [SW-1:0]    cell_val [MAX_FRAMES];

  assign accept = in_valid && !in_stall;
  assign room   = cnt_r < CNT_W'(MAX_FRAMES);
  assign ins    = accept && room;
  assign load   = (state_r == ptbe_pkg::ST_LOAD) && (!out_valid_r || !out_stall);
  assign clr    = load;

  // Sorter chain: cell 0 sees a permanently settled left edge.
  assign links[0] = '{val: '0, valid: 1'b1, gt: 1'b0};

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    ptbe_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ins    (ins),
      .clr    (clr),
      .sample (in_pixel_sample),
      .left   (links[i]),
      .right  (links[i+1])
    );
    assign cell_val[i] = links[i+1].val;
  end

  ptbe_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (sum_r),
    .divisor   (cnt_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Window statistics, updated per accepted beat; overflow drops the beat.
  assign pair_hi = (pfirst_r > in_pixel_sample) ? pfirst_r : in_pixel_sample;

  always_comb begin
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    rmin_nxt   = rmin_r;
    pfirst_nxt = pfirst_r;
    popen_nxt  = popen_r;
    pmin_nxt   = pmin_r;
    ovf_nxt    = ovf_r;
    last_nxt   = last_r;
    if (clr) begin
      cnt_nxt   = '0;
      sum_nxt   = '0;
      rmin_nxt  = ptbe_pkg::SAMPLE_MAX;
      popen_nxt = 1'b0;
      pmin_nxt  = ptbe_pkg::SAMPLE_MAX;
      ovf_nxt   = 1'b0;
    end else if (accept) begin
      last_nxt = in_window_end;
      if (room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        sum_nxt = sum_r + SUM_W'(in_pixel_sample);
        if (in_pixel_sample < rmin_r) begin
          rmin_nxt = in_pixel_sample;
        end
        if (popen_r) begin
          if (pair_hi < pmin_r) begin
            pmin_nxt = pair_hi;
          end
          popen_nxt = 1'b0;
        end else begin
          pfirst_nxt = in_pixel_sample;
          popen_nxt  = 1'b1;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // Median pick and average rounding, ties to even.
  assign med_full  = cnt_r >> 1;
  assign med_idx   = med_full[IDX_W-1:0];
  assign twice_rem = {div_r, 1'b0};
  assign round_up  = (twice_rem > {1'b0, cnt_r}) ||
                     ((twice_rem == {1'b0, cnt_r}) && div_q[0]);
  assign q_round   = {1'b0, div_q} + (SUM_W+1)'(round_up);
  assign avg_round = (|q_round[SUM_W:SW]) ? ptbe_pkg::SAMPLE_MAX : q_round[SW-1:0];

  always_comb begin
    unique case (mode_r)
      ptbe_pkg::MODE_MIN:    est_now = rmin_r;
      ptbe_pkg::MODE_MINMAX: est_now = (popen_r && pfirst_r < pmin_r) ? pfirst_r : pmin_r;
      ptbe_pkg::MODE_AVG:    est_now = avg_round;
      ptbe_pkg::MODE_MEDIAN: est_now = cell_val[med_idx];
      default:               est_now = rmin_r;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptbe_pkg::ST_IDLE: begin
        if (accept && in_window_end) begin
          state_nxt = ptbe_pkg::ST_EVAL;
        end
      end
      ptbe_pkg::ST_EVAL: begin
        state_nxt = (mode_r == ptbe_pkg::MODE_AVG) ? ptbe_pkg::ST_DIV : ptbe_pkg::ST_LOAD;
      end
      ptbe_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ptbe_pkg::ST_LOAD;
        end
      end
      ptbe_pkg::ST_LOAD: begin
        if (load) begin
          state_nxt = ptbe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptbe_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    est_nxt   = est_r;
    unique case (state_r)
      ptbe_pkg::ST_IDLE: in_stall = 1'b0;
      ptbe_pkg::ST_EVAL: begin
        div_start = (mode_r == ptbe_pkg::MODE_AVG);
        est_nxt   = est_now;
      end
      ptbe_pkg::ST_DIV: begin
        if (div_done) begin
          est_nxt = est_now;
        end
      end
      ptbe_pkg::ST_LOAD: in_stall = 1'b1;
      default:           in_stall = 1'b1;
    endcase
  end

  // Output register: hold while stalled, load a finished window.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = est_r;
      out_err_nxt   = ovf_r;
    end
  end

  assign mode_nxt = cfg_wr_en ? ptbe_pkg::mode_t'(cfg_wr_data) : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ptbe_pkg::MODE_MIN;
      state_r     <= ptbe_pkg::ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      rmin_r      <= ptbe_pkg::SAMPLE_MAX;
      pfirst_r    <= '0;
      popen_r     <= 1'b0;
      pmin_r      <= ptbe_pkg::SAMPLE_MAX;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      rmin_r      <= rmin_nxt;
      pfirst_r    <= pfirst_nxt;
      popen_r     <= popen_nxt;
      pmin_r      <= pmin_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    est_r     <= est_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_background_value = out_val_r;
  assign out_window_error     = out_err_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAMES))
    else $error("sample count beyond window depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CNT_W'(MAX_FRAMES)))
    else $error("overflow flagged with room left");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == '0) && (state_r == ptbe_pkg::ST_IDLE) && out_valid_r)
    else $error("window not cleared after result load");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ptbe_pkg::ST_DIV))
    else $error("divider finished outside divide state");

  a_eval_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptbe_pkg::ST_EVAL) |-> last_r)
    else $error("evaluation without closing beat");

endmodule
